// File: hdl/color_temperature_gamma_ramp_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the color temperature gamma ramp unit
// Shared property wrappers; clk and rst_n are taken from the using module.
// ----------------------------------------------------------------------------
`ifndef COLOR_TEMPERATURE_GAMMA_RAMP_UNIT_MACROS_SVH
`define COLOR_TEMPERATURE_GAMMA_RAMP_UNIT_MACROS_SVH

// same-cycle implication
`define CTGR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctgr: same-cycle check failed");

// next-cycle implication
`define CTGR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctgr: next-cycle check failed");

`endif

// File: hdl/ctgr_pkg.sv
// ----------------------------------------------------------------------------
// ctgr_pkg
// Types, constants and the blackbody ROM of the color temperature ramp unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ctgr_pkg;

    localparam int unsigned KELVIN_W   = 14;
    localparam int unsigned GAIN_W     = 13;
    localparam int unsigned INDEX_W    = 8;
    localparam int unsigned LEVEL_W    = 16;
    localparam int unsigned RAMP_W     = 16;
    localparam int unsigned ROM_IDX_W  = 7;
    localparam int unsigned REM_W      = 7;
    localparam int unsigned CHAN_W     = 17;   // Q1.16
    localparam int unsigned SUM_W      = 23;
    localparam int unsigned CG_W       = CHAN_W + GAIN_W;
    localparam int unsigned PROD_W     = RAMP_W + CG_W;
    localparam int unsigned DEC_W      = 27;
    localparam int unsigned ROM_LEN    = 91;
    localparam int unsigned NUM_CH     = 3;
    localparam int unsigned ADDR_W     = 3;
    localparam int unsigned DATA_W     = 32;

    localparam int unsigned CH_RED     = 2;
    localparam int unsigned CH_GREEN   = 1;
    localparam int unsigned CH_BLUE    = 0;

    localparam logic [KELVIN_W-1:0]  KELVIN_MIN   = 14'd1000;
    localparam logic [KELVIN_W-1:0]  KELVIN_MAX   = 14'd10000;
    localparam logic [KELVIN_W-1:0]  KELVIN_RESET = 14'd6500;
    localparam logic [REM_W-1:0]     KELVIN_STEP  = 7'd100;
    localparam logic [GAIN_W-1:0]    GAIN_MIN     = 13'd410;
    localparam logic [GAIN_W-1:0]    GAIN_ONE     = 13'd4096;
    localparam logic [ROM_IDX_W-1:0] ROM_LAST     = 7'd90;
    localparam logic [LEVEL_W-1:0]   LEVEL_MAX    = 16'hFFFF;
    localparam logic [CHAN_W-1:0]    CHAN_ONE     = 17'd65536;

    // d / 100 for d < 2^14: (d * 5243) >> 19
    localparam logic [12:0]          STEP_RECIP   = 13'd5243;
    localparam int unsigned          STEP_SHIFT   = 19;
    // s / 100 for s < 2^23: (s * ceil(2^30/100)) >> 30
    localparam logic [23:0]          SUM_RECIP    = 24'd10737419;
    localparam int unsigned          SUM_SHIFT    = 30;
    localparam int unsigned          LEVEL_SHIFT  = 28;

    // register addresses (byte)
    localparam logic [ADDR_W-1:0]    REG_KELVIN   = 3'd0;
    localparam logic [ADDR_W-1:0]    REG_GAIN     = 3'd4;

    localparam logic [DEC_W-1:0]     DEC_ONE      = 27'd100000000;
    localparam longint unsigned      DEC_SCALE    = 64'd100000000;
    localparam longint unsigned      DEC_HALF     = 64'd50000000;

    typedef struct packed {
        logic [KELVIN_W-1:0] kelvin;
        logic [GAIN_W-1:0]   gain;
    } cfg_t;

    typedef logic [NUM_CH-1:0][CHAN_W-1:0] chan_vec_t;

    typedef struct packed {
        logic [RAMP_W-1:0] ramp;
        logic [GAIN_W-1:0] gain;
        chan_vec_t         chan;
    } item_t;

    typedef logic [NUM_CH-1:0][DEC_W-1:0]  dec_row_t;
    typedef logic [ROM_LEN-1:0][NUM_CH-1:0][CHAN_W-1:0] rom_t;

    // blackbody table, 8 decimal digits, {red, green, blue}
    function automatic dec_row_t bb_dec_row(input int unsigned i);
        dec_row_t r;
        unique case (i)
            0:  r = {DEC_ONE, 27'd18172716, 27'd0};
            1:  r = {DEC_ONE, 27'd25503671, 27'd0};
            2:  r = {DEC_ONE, 27'd30942099, 27'd0};
            3:  r = {DEC_ONE, 27'd35357379, 27'd0};
            4:  r = {DEC_ONE, 27'd39091524, 27'd0};
            5:  r = {DEC_ONE, 27'd42322816, 27'd0};
            6:  r = {DEC_ONE, 27'd45159884, 27'd0};
            7:  r = {DEC_ONE, 27'd47675916, 27'd0};
            8:  r = {DEC_ONE, 27'd49923747, 27'd0};
            9:  r = {DEC_ONE, 27'd51943421, 27'd0};
            10: r = {DEC_ONE, 27'd54360078, 27'd8679949};
            11: r = {DEC_ONE, 27'd56618736, 27'd14065513};
            12: r = {DEC_ONE, 27'd58734976, 27'd18362641};
            13: r = {DEC_ONE, 27'd60724493, 27'd22137978};
            14: r = {DEC_ONE, 27'd62600248, 27'd25591950};
            15: r = {DEC_ONE, 27'd64373109, 27'd28819679};
            16: r = {DEC_ONE, 27'd66052319, 27'd31873863};
            17: r = {DEC_ONE, 27'd67645822, 27'd34786758};
            18: r = {DEC_ONE, 27'd69160518, 27'd37579588};
            19: r = {DEC_ONE, 27'd70602449, 27'd40267128};
            20: r = {DEC_ONE, 27'd71976951, 27'd42860152};
            21: r = {DEC_ONE, 27'd73288760, 27'd45366838};
            22: r = {DEC_ONE, 27'd74542112, 27'd47793608};
            23: r = {DEC_ONE, 27'd75740814, 27'd50145662};
            24: r = {DEC_ONE, 27'd76888303, 27'd52427322};
            25: r = {DEC_ONE, 27'd77987699, 27'd54642268};
            26: r = {DEC_ONE, 27'd79041843, 27'd56793692};
            27: r = {DEC_ONE, 27'd80053332, 27'd58884417};
            28: r = {DEC_ONE, 27'd81024551, 27'd60916971};
            29: r = {DEC_ONE, 27'd81957693, 27'd62893653};
            30: r = {DEC_ONE, 27'd82854786, 27'd64816570};
            31: r = {DEC_ONE, 27'd83717703, 27'd66687674};
            32: r = {DEC_ONE, 27'd84548188, 27'd68508786};
            33: r = {DEC_ONE, 27'd85347859, 27'd70281616};
            34: r = {DEC_ONE, 27'd86118227, 27'd72007777};
            35: r = {DEC_ONE, 27'd86860704, 27'd73688797};
            36: r = {DEC_ONE, 27'd87576611, 27'd75326132};
            37: r = {DEC_ONE, 27'd88267187, 27'd76921169};
            38: r = {DEC_ONE, 27'd88933596, 27'd78475236};
            39: r = {DEC_ONE, 27'd89576933, 27'd79989606};
            40: r = {DEC_ONE, 27'd90198230, 27'd81465502};
            41: r = {DEC_ONE, 27'd90963069, 27'd82838210};
            42: r = {DEC_ONE, 27'd91710889, 27'd84190889};
            43: r = {DEC_ONE, 27'd92441842, 27'd85523742};
            44: r = {DEC_ONE, 27'd93156127, 27'd86836903};
            45: r = {DEC_ONE, 27'd93853986, 27'd88130458};
            46: r = {DEC_ONE, 27'd94535695, 27'd89404470};
            47: r = {DEC_ONE, 27'd95201559, 27'd90658983};
            48: r = {DEC_ONE, 27'd95851906, 27'd91894041};
            49: r = {DEC_ONE, 27'd96487079, 27'd93109690};
            50: r = {DEC_ONE, 27'd97107439, 27'd94305985};
            51: r = {DEC_ONE, 27'd97713351, 27'd95482993};
            52: r = {DEC_ONE, 27'd98305189, 27'd96640795};
            53: r = {DEC_ONE, 27'd98883326, 27'd97779486};
            54: r = {DEC_ONE, 27'd99448139, 27'd98899179};
            55: r = {DEC_ONE, DEC_ONE, DEC_ONE};
            56: r = {27'd98947904, 27'd99348723, DEC_ONE};
            57: r = {27'd97940448, 27'd98722715, DEC_ONE};
            58: r = {27'd96975025, 27'd98120637, DEC_ONE};
            59: r = {27'd96049223, 27'd97541240, DEC_ONE};
            60: r = {27'd95160805, 27'd96983355, DEC_ONE};
            61: r = {27'd94303638, 27'd96443333, DEC_ONE};
            62: r = {27'd93480451, 27'd95923080, DEC_ONE};
            63: r = {27'd92689056, 27'd95421394, DEC_ONE};
            64: r = {27'd91927697, 27'd94937330, DEC_ONE};
            65: r = {27'd91194747, 27'd94470005, DEC_ONE};
            66: r = {27'd90488690, 27'd94018594, DEC_ONE};
            67: r = {27'd89808115, 27'd93582323, DEC_ONE};
            68: r = {27'd89151710, 27'd93160469, DEC_ONE};
            69: r = {27'd88518247, 27'd92752354, DEC_ONE};
            70: r = {27'd87906581, 27'd92357340, DEC_ONE};
            71: r = {27'd87315640, 27'd91974827, DEC_ONE};
            72: r = {27'd86744421, 27'd91604254, DEC_ONE};
            73: r = {27'd86191983, 27'd91245088, DEC_ONE};
            74: r = {27'd85657444, 27'd90896831, DEC_ONE};
            75: r = {27'd85139976, 27'd90559011, DEC_ONE};
            76: r = {27'd84638799, 27'd90231183, DEC_ONE};
            77: r = {27'd84153180, 27'd89912926, DEC_ONE};
            78: r = {27'd83682430, 27'd89603843, DEC_ONE};
            79: r = {27'd83225897, 27'd89303558, DEC_ONE};
            80: r = {27'd82782969, 27'd89011714, DEC_ONE};
            81: r = {27'd82353066, 27'd88727974, DEC_ONE};
            82: r = {27'd81935641, 27'd88452017, DEC_ONE};
            83: r = {27'd81530175, 27'd88183541, DEC_ONE};
            84: r = {27'd81136180, 27'd87922257, DEC_ONE};
            85: r = {27'd80753191, 27'd87667891, DEC_ONE};
            86: r = {27'd80380769, 27'd87420182, DEC_ONE};
            87: r = {27'd80018497, 27'd87178882, DEC_ONE};
            88: r = {27'd79665980, 27'd86943756, DEC_ONE};
            89: r = {27'd79322843, 27'd86714579, DEC_ONE};
            90: r = {27'd78988728, 27'd86491137, DEC_ONE};
            default: r = '0;
        endcase
        return r;
    endfunction

    // nearest Q1.16, ties up; evaluated at elaboration only
    function automatic logic [CHAN_W-1:0] q116(input logic [DEC_W-1:0] x);
        longint unsigned t;
        t = ((longint'(x) * 64'd65536) + DEC_HALF) / DEC_SCALE;
        return t[CHAN_W-1:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t     rom;
        dec_row_t row;
        for (int unsigned i = 0; i < ROM_LEN; i++) begin
            row = bb_dec_row(i);
            for (int unsigned ch = 0; ch < NUM_CH; ch++) begin
                rom[i][ch] = q116(row[ch]);
            end
        end
        return rom;
    endfunction

    localparam rom_t BB_ROM = build_rom();

endpackage

`default_nettype wire

// File: hdl/ctgr_regs.sv
// ----------------------------------------------------------------------------
// ctgr_regs
// APB-style register file: temperature and brightness settings.
// ----------------------------------------------------------------------------
`default_nettype none

module ctgr_regs
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ctgr_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ctgr_pkg::DATA_W-1:0]   pwdata,
    output logic      [ctgr_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output ctgr_pkg::cfg_t                     cfg
);

    logic [ctgr_pkg::KELVIN_W-1:0] kelvin_reg, kelvin_next;
    logic [ctgr_pkg::GAIN_W-1:0]   gain_reg, gain_next;
    logic                          wr_en;
    logic                          sel_gain;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite;
    // decode on the word address bit, byte offset ignored
    assign sel_gain = paddr[2] == ctgr_pkg::REG_GAIN[2];

    always_comb
    begin
        kelvin_next = kelvin_reg;
        gain_next   = gain_reg;
        if (wr_en)
        begin
            if (sel_gain)
            begin
                gain_next = pwdata[ctgr_pkg::GAIN_W-1:0];
            end
            else
            begin
                kelvin_next = pwdata[ctgr_pkg::KELVIN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kelvin_reg <= ctgr_pkg::KELVIN_RESET;
            gain_reg   <= ctgr_pkg::GAIN_ONE;
        end
        else
        begin
            kelvin_reg <= kelvin_next;
            gain_reg   <= gain_next;
        end
    end

    always_comb
    begin
        if (sel_gain)
        begin
            prdata = ctgr_pkg::DATA_W'(gain_reg);
        end
        else
        begin
            prdata = ctgr_pkg::DATA_W'(kelvin_reg);
        end
    end

    assign cfg.kelvin = kelvin_reg;
    assign cfg.gain   = gain_reg;

endmodule

`default_nettype wire

// File: hdl/ctgr_interp.sv
// ----------------------------------------------------------------------------
// ctgr_interp
// Three-stage front end: clamp and split, ROM interpolation, divide by 100.
// ----------------------------------------------------------------------------
`default_nettype none

`include "color_temperature_gamma_ramp_unit_macros.svh"

module ctgr_interp
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ctgr_pkg::cfg_t                cfg,
    input  wire logic                          ramp_valid,
    output logic                               ramp_ready,
    input  wire logic [ctgr_pkg::INDEX_W-1:0]  ramp_index,
    output logic                               item_valid,
    input  wire logic                          item_ready,
    output ctgr_pkg::item_t                    item
);

    localparam int unsigned NCH = ctgr_pkg::NUM_CH;

    // stage 1: clamped settings, 100 K step and remainder
    logic                             s1_vld_reg, s1_vld_next;
    logic [ctgr_pkg::RAMP_W-1:0]      s1_ramp_reg, s1_ramp_next;
    logic [ctgr_pkg::GAIN_W-1:0]      s1_gain_reg, s1_gain_next;
    logic [ctgr_pkg::ROM_IDX_W-1:0]   s1_idx_reg, s1_idx_next;
    logic [ctgr_pkg::REM_W-1:0]       s1_rem_reg, s1_rem_next;
    // stage 2: weighted sums
    logic                             s2_vld_reg, s2_vld_next;
    logic [ctgr_pkg::RAMP_W-1:0]      s2_ramp_reg;
    logic [ctgr_pkg::GAIN_W-1:0]      s2_gain_reg;
    logic [NCH-1:0][ctgr_pkg::SUM_W-1:0] s2_sum_reg, s2_sum_next;
    // stage 3: interpolated channels
    logic                             s3_vld_reg, s3_vld_next;
    logic [ctgr_pkg::RAMP_W-1:0]      s3_ramp_reg;
    logic [ctgr_pkg::GAIN_W-1:0]      s3_gain_reg;
    ctgr_pkg::chan_vec_t              s3_chan_reg, s3_chan_next;

    logic en1, en2, en3;

    logic [ctgr_pkg::KELVIN_W-1:0]    k_clamp;
    logic [ctgr_pkg::KELVIN_W-1:0]    k_off;
    logic [26:0]                      step_prod;
    logic [ctgr_pkg::KELVIN_W-1:0]    step_base;
    logic [ctgr_pkg::ROM_IDX_W-1:0]   idx_hi;
    logic [ctgr_pkg::REM_W-1:0]       w_lo;
    logic [ctgr_pkg::CHAN_W-1:0]      lo_val, hi_val;
    logic [46:0]                      div_prod;

    assign en3        = !s3_vld_reg || item_ready;
    assign en2        = !s2_vld_reg || en3;
    assign en1        = !s1_vld_reg || en2;
    assign ramp_ready = en1;

    assign s1_vld_next = en1 ? ramp_valid : s1_vld_reg;
    assign s2_vld_next = en2 ? s1_vld_reg : s2_vld_reg;
    assign s3_vld_next = en3 ? s2_vld_reg : s3_vld_reg;

    // stage 1 logic
    always_comb
    begin
        priority if (cfg.kelvin < ctgr_pkg::KELVIN_MIN)
        begin
            k_clamp = ctgr_pkg::KELVIN_MIN;
        end
        else if (cfg.kelvin > ctgr_pkg::KELVIN_MAX)
        begin
            k_clamp = ctgr_pkg::KELVIN_MAX;
        end
        else
        begin
            k_clamp = cfg.kelvin;
        end

        priority if (cfg.gain < ctgr_pkg::GAIN_MIN)
        begin
            s1_gain_next = ctgr_pkg::GAIN_MIN;
        end
        else if (cfg.gain > ctgr_pkg::GAIN_ONE)
        begin
            s1_gain_next = ctgr_pkg::GAIN_ONE;
        end
        else
        begin
            s1_gain_next = cfg.gain;
        end

        k_off       = k_clamp - ctgr_pkg::KELVIN_MIN;
        step_prod   = 27'(k_off) * 27'(ctgr_pkg::STEP_RECIP);
        s1_idx_next = step_prod[ctgr_pkg::STEP_SHIFT +: ctgr_pkg::ROM_IDX_W];
        step_base   = ctgr_pkg::KELVIN_W'(s1_idx_next)
                    * ctgr_pkg::KELVIN_W'(ctgr_pkg::KELVIN_STEP);
        s1_rem_next = ctgr_pkg::REM_W'(k_off - step_base);
        // index * 257
        s1_ramp_next = {ramp_index, ramp_index};
    end

    // stage 2 logic: lo*(100-rem) + hi*rem + 50
    always_comb
    begin
        idx_hi = (s1_idx_reg == ctgr_pkg::ROM_LAST) ? s1_idx_reg
                                                    : s1_idx_reg + ctgr_pkg::ROM_IDX_W'(1);
        w_lo   = ctgr_pkg::KELVIN_STEP - s1_rem_reg;
        lo_val = '0;
        hi_val = '0;
        for (int unsigned ch = 0; ch < NCH; ch++)
        begin
            lo_val = ctgr_pkg::BB_ROM[s1_idx_reg][ch];
            hi_val = ctgr_pkg::BB_ROM[idx_hi][ch];
            s2_sum_next[ch] = ctgr_pkg::SUM_W'(lo_val) * ctgr_pkg::SUM_W'(w_lo)
                            + ctgr_pkg::SUM_W'(hi_val) * ctgr_pkg::SUM_W'(s1_rem_reg)
                            + ctgr_pkg::SUM_W'(ctgr_pkg::KELVIN_STEP >> 1);
        end
    end

    // stage 3 logic: exact divide by 100 through a reciprocal
    always_comb
    begin
        div_prod = '0;
        for (int unsigned ch = 0; ch < NCH; ch++)
        begin
            div_prod = 47'(s2_sum_reg[ch]) * 47'(ctgr_pkg::SUM_RECIP);
            s3_chan_next[ch] = div_prod[ctgr_pkg::SUM_SHIFT +: ctgr_pkg::CHAN_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
            s3_vld_reg <= s3_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_ramp_reg <= s1_ramp_next;
            s1_gain_reg <= s1_gain_next;
            s1_idx_reg  <= s1_idx_next;
            s1_rem_reg  <= s1_rem_next;
        end
        if (en2)
        begin
            s2_ramp_reg <= s1_ramp_reg;
            s2_gain_reg <= s1_gain_reg;
            s2_sum_reg  <= s2_sum_next;
        end
        if (en3)
        begin
            s3_ramp_reg <= s2_ramp_reg;
            s3_gain_reg <= s2_gain_reg;
            s3_chan_reg <= s3_chan_next;
        end
    end

    assign item_valid = s3_vld_reg;
    assign item.ramp  = s3_ramp_reg;
    assign item.gain  = s3_gain_reg;
    assign item.chan  = s3_chan_reg;

    // only 10000 K reaches the last ROM row, so no remainder there
    `CTGR_ASSERT_NOW(a_last_row_no_rem, s1_vld_reg && s1_idx_reg == ctgr_pkg::ROM_LAST, s1_rem_reg == '0)
    // interpolation stays inside Q1.16 unit range
    `CTGR_ASSERT_NOW(a_chan_in_range, s3_vld_reg, s3_chan_reg[0] <= ctgr_pkg::CHAN_ONE && s3_chan_reg[1] <= ctgr_pkg::CHAN_ONE && s3_chan_reg[2] <= ctgr_pkg::CHAN_ONE)
    // a held beat is never dropped
    `CTGR_ASSERT_NEXT(a_hold_on_stall, s3_vld_reg && !item_ready, s3_vld_reg && $stable(s3_chan_reg))

endmodule

`default_nettype wire

// File: hdl/ctgr_scale.sv
// ----------------------------------------------------------------------------
// ctgr_scale
// Two-stage back end: channel times brightness, then ramp times that.
// ----------------------------------------------------------------------------
`default_nettype none

`include "color_temperature_gamma_ramp_unit_macros.svh"

module ctgr_scale
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire ctgr_pkg::item_t               item,
    output logic                               level_valid,
    input  wire logic                          level_ready,
    output logic [ctgr_pkg::LEVEL_W-1:0]       red_level,
    output logic [ctgr_pkg::LEVEL_W-1:0]       green_level,
    output logic [ctgr_pkg::LEVEL_W-1:0]       blue_level
);

    localparam int unsigned NCH = ctgr_pkg::NUM_CH;

    logic                                 s4_vld_reg, s4_vld_next;
    logic [ctgr_pkg::RAMP_W-1:0]          s4_ramp_reg;
    logic [NCH-1:0][ctgr_pkg::CG_W-1:0]   s4_cg_reg, s4_cg_next;
    logic                                 s5_vld_reg, s5_vld_next;
    logic [NCH-1:0][ctgr_pkg::LEVEL_W-1:0] s5_lvl_reg, s5_lvl_next;

    logic                                 en4, en5;
    logic [ctgr_pkg::PROD_W-1:0]          prod;
    logic [ctgr_pkg::PROD_W-ctgr_pkg::LEVEL_SHIFT-1:0] lvl_wide;

    assign en5        = !s5_vld_reg || level_ready;
    assign en4        = !s4_vld_reg || en5;
    assign item_ready = en4;

    assign s4_vld_next = en4 ? item_valid : s4_vld_reg;
    assign s5_vld_next = en5 ? s4_vld_reg : s5_vld_reg;

    always_comb
    begin
        for (int unsigned ch = 0; ch < NCH; ch++)
        begin
            s4_cg_next[ch] = ctgr_pkg::CG_W'(item.chan[ch]) * ctgr_pkg::CG_W'(item.gain);
        end
    end

    // floor(ramp * c * gain / 2^28), saturated
    always_comb
    begin
        prod     = '0;
        lvl_wide = '0;
        for (int unsigned ch = 0; ch < NCH; ch++)
        begin
            prod     = ctgr_pkg::PROD_W'(s4_ramp_reg) * ctgr_pkg::PROD_W'(s4_cg_reg[ch]);
            lvl_wide = prod[ctgr_pkg::PROD_W-1:ctgr_pkg::LEVEL_SHIFT];
            if (lvl_wide > ($bits(lvl_wide))'(ctgr_pkg::LEVEL_MAX))
            begin
                s5_lvl_next[ch] = ctgr_pkg::LEVEL_MAX;
            end
            else
            begin
                s5_lvl_next[ch] = lvl_wide[ctgr_pkg::LEVEL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            s4_vld_reg <= s4_vld_next;
            s5_vld_reg <= s5_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_ramp_reg <= item.ramp;
            s4_cg_reg   <= s4_cg_next;
        end
        if (en5)
        begin
            s5_lvl_reg <= s5_lvl_next;
        end
    end

    assign level_valid = s5_vld_reg;
    assign red_level   = s5_lvl_reg[ctgr_pkg::CH_RED];
    assign green_level = s5_lvl_reg[ctgr_pkg::CH_GREEN];
    assign blue_level  = s5_lvl_reg[ctgr_pkg::CH_BLUE];

    // channel (<= 1.0) times gain (<= 1.0) stays at or below 2^28
    `CTGR_ASSERT_NOW(a_cg_bound, s4_vld_reg, s4_cg_reg[0] <= 30'h1000_0000 && s4_cg_reg[1] <= 30'h1000_0000 && s4_cg_reg[2] <= 30'h1000_0000)
    // ramp index zero gives black
    `CTGR_ASSERT_NEXT(a_zero_ramp, s4_vld_reg && en5 && s4_ramp_reg == '0, s5_lvl_reg == '0)
    // a beat waiting in the multiplier stage is kept across a stall
    `CTGR_ASSERT_NEXT(a_s4_hold, s4_vld_reg && !en5, s4_vld_reg && $stable(s4_cg_reg))

endmodule

`default_nettype wire

// File: hdl/color_temperature_gamma_ramp_unit.sv
// ----------------------------------------------------------------------------
// color_temperature_gamma_ramp_unit
// Gamma ramp levels for a blackbody color temperature and a brightness.
// ----------------------------------------------------------------------------
// Takes one ramp index per clock while ramp_ready is high and returns one beat
// of red, green and blue levels per index through five register stages: clamp
// and split, ROM interpolation, divide by 100, brightness multiply, ramp
// multiply with saturation. Every stage stalls on its own, so bubbles
// close up and the throughput is one beat per cycle whenever the output side
// takes beats. Temperature (byte address 0) and brightness (byte address 4)
// are read live, so write them only while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module color_temperature_gamma_ramp_unit
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ctgr_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ctgr_pkg::DATA_W-1:0]   pwdata,
    output logic      [ctgr_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          ramp_valid,
    output logic                               ramp_ready,
    input  wire logic [ctgr_pkg::INDEX_W-1:0]  ramp_index,
    output logic                               level_valid,
    input  wire logic                          level_ready,
    output logic [ctgr_pkg::LEVEL_W-1:0]       red_level,
    output logic [ctgr_pkg::LEVEL_W-1:0]       green_level,
    output logic [ctgr_pkg::LEVEL_W-1:0]       blue_level
);

    ctgr_pkg::cfg_t  cfg;
    ctgr_pkg::item_t item;
    logic            item_valid;
    logic            item_ready;

    ctgr_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ctgr_interp u_interp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .ramp_valid (ramp_valid),
        .ramp_ready (ramp_ready),
        .ramp_index (ramp_index),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    ctgr_scale u_scale
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .level_valid (level_valid),
        .level_ready (level_ready),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level)
    );

endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Color temperature gamma ramp unit testbench
// Programs temperature and brightness over the register port, streams ramp
// indexes through the valid/ready input and checks every level beat against
// a blackbody interpolation predictor kept inside the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int unsigned IDLE_PCT    = 29;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES = 20;

    localparam int unsigned K_MIN     = 1000;
    localparam int unsigned K_MAX     = 10000;
    localparam int unsigned K_STEP    = 100;
    localparam int unsigned G_MIN     = 410;
    localparam int unsigned G_ONE     = 4096;
    localparam int unsigned ROM_ROWS  = 91;
    localparam int unsigned PER_INDEX = 257;
    localparam longint unsigned LEVEL_TOP = 65535;
    localparam longint unsigned DEC_UNITY = 100000000;

    typedef enum int {RED = 0, GREEN = 1, BLUE = 2} channel_e;

    typedef struct packed {
        logic [ctgr_pkg::INDEX_W-1:0]         index;
        logic [2:0][ctgr_pkg::LEVEL_W-1:0]    level;
    } ramp_levels_t;

    // blackbody table, 8 decimal digits; rows not listed are 0 or 1.0
    int unsigned green_bb [0:90] = '{
        18172716, 25503671, 30942099, 35357379, 39091524, 42322816, 45159884, 47675916,
        49923747, 51943421, 54360078, 56618736, 58734976, 60724493, 62600248, 64373109,
        66052319, 67645822, 69160518, 70602449, 71976951, 73288760, 74542112, 75740814,
        76888303, 77987699, 79041843, 80053332, 81024551, 81957693, 82854786, 83717703,
        84548188, 85347859, 86118227, 86860704, 87576611, 88267187, 88933596, 89576933,
        90198230, 90963069, 91710889, 92441842, 93156127, 93853986, 94535695, 95201559,
        95851906, 96487079, 97107439, 97713351, 98305189, 98883326, 99448139, 100000000,
        99348723, 98722715, 98120637, 97541240, 96983355, 96443333, 95923080, 95421394,
        94937330, 94470005, 94018594, 93582323, 93160469, 92752354, 92357340, 91974827,
        91604254, 91245088, 90896831, 90559011, 90231183, 89912926, 89603843, 89303558,
        89011714, 88727974, 88452017, 88183541, 87922257, 87667891, 87420182, 87178882,
        86943756, 86714579, 86491137
    };
    // red below 1.0 from row 56 on
    int unsigned red_bb_hot [0:34] = '{
        98947904, 97940448, 96975025, 96049223, 95160805, 94303638, 93480451, 92689056,
        91927697, 91194747, 90488690, 89808115, 89151710, 88518247, 87906581, 87315640,
        86744421, 86191983, 85657444, 85139976, 84638799, 84153180, 83682430, 83225897,
        82782969, 82353066, 81935641, 81530175, 81136180, 80753191, 80380769, 80018497,
        79665980, 79322843, 78988728
    };
    // blue is zero up to row 9 and 1.0 from row 55
    int unsigned blue_bb_mid [0:44] = '{
        8679949,  14065513, 18362641, 22137978, 25591950, 28819679, 31873863, 34786758,
        37579588, 40267128, 42860152, 45366838, 47793608, 50145662, 52427322, 54642268,
        56793692, 58884417, 60916971, 62893653, 64816570, 66687674, 68508786, 70281616,
        72007777, 73688797, 75326132, 76921169, 78475236, 79989606, 81465502, 82838210,
        84190889, 85523742, 86836903, 88130458, 89404470, 90658983, 91894041, 93109690,
        94305985, 95482993, 96640795, 97779486, 98899179
    };

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [ctgr_pkg::ADDR_W-1:0]       paddr = '0;
    logic [ctgr_pkg::DATA_W-1:0]       pwdata = '0;
    logic [ctgr_pkg::DATA_W-1:0]       prdata;
    logic                              pready;
    logic                              ramp_valid = 1'b0;
    logic                              ramp_ready;
    logic [ctgr_pkg::INDEX_W-1:0]      ramp_index = '0;
    logic                              level_valid;
    logic                              level_ready = 1'b0;
    logic [ctgr_pkg::LEVEL_W-1:0]      red_level;
    logic [ctgr_pkg::LEVEL_W-1:0]      green_level;
    logic [ctgr_pkg::LEVEL_W-1:0]      blue_level;

    color_temperature_gamma_ramp_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .ramp_valid  (ramp_valid),
        .ramp_ready  (ramp_ready),
        .ramp_index  (ramp_index),
        .level_valid (level_valid),
        .level_ready (level_ready),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level)
    );

    logic [ctgr_pkg::KELVIN_W-1:0]     kelvin_cfg = 14'd6500;
    logic [ctgr_pkg::GAIN_W-1:0]       gain_cfg = 13'd4096;

    logic [ctgr_pkg::INDEX_W-1:0]      index_queue [$];
    ramp_levels_t                      level_queue [$];
    ramp_levels_t                      want;
    ramp_levels_t                      got;

    bit          in_fire;
    bit          out_fire;
    bit          sender_hold = 1'b0;
    bit          steady = 1'b0;
    int unsigned error_count = 0;
    int unsigned stall_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned bb_q116(input int unsigned row, input channel_e ch);
        longint unsigned dec;
        unique case (ch)
            RED:
                if (row <= 55)
                    dec = DEC_UNITY;
                else
                    dec = red_bb_hot[row - 56];
            GREEN:
                dec = green_bb[row];
            default:
                if (row < 10)
                    dec = 0;
                else if (row >= 55)
                    dec = DEC_UNITY;
                else
                    dec = blue_bb_mid[row - 10];
        endcase
        // nearest Q1.16, ties up
        return (dec * 65536 + DEC_UNITY / 2) / DEC_UNITY;
    endfunction

    function automatic ramp_levels_t predict_levels(input logic [ctgr_pkg::INDEX_W-1:0] idx,
                                                    input logic [ctgr_pkg::KELVIN_W-1:0] kel,
                                                    input logic [ctgr_pkg::GAIN_W-1:0] gn);
        int unsigned     k;
        int unsigned     g;
        int unsigned     row;
        int unsigned     rem;
        longint unsigned chan;
        longint unsigned lvl;
        ramp_levels_t    res;
        k = kel;
        g = gn;
        if (k < K_MIN) k = K_MIN;
        if (k > K_MAX) k = K_MAX;
        if (g < G_MIN) g = G_MIN;
        if (g > G_ONE) g = G_ONE;
        row = (k - K_MIN) / K_STEP;
        rem = (k - K_MIN) % K_STEP;
        res.index = idx;
        for (int i = 0; i < 3; i++)
        begin
            if (row >= ROM_ROWS - 1)
                chan = bb_q116(ROM_ROWS - 1, channel_e'(i));
            else
                chan = (bb_q116(row, channel_e'(i)) * (K_STEP - rem)
                        + bb_q116(row + 1, channel_e'(i)) * rem + K_STEP / 2) / K_STEP;
            lvl = (longint'(idx) * PER_INDEX * chan * g) >> 28;
            if (lvl > LEVEL_TOP)
                lvl = LEVEL_TOP;
            res.level[i] = lvl[ctgr_pkg::LEVEL_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [ctgr_pkg::INDEX_W-1:0] random_index();
        if ($urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
        return ctgr_pkg::INDEX_W'($urandom_range(0, 255));
    endfunction

    task automatic report(input string msg);
        error_count++;
        $display("%0t MISMATCH %s", $time, msg);
    endtask

    // input driver: holds a beat until accepted, idles at random otherwise
    always @(negedge clk)
    begin
        if (!rst_n)
            ramp_valid <= 1'b0;
        else if (!ramp_valid || in_fire)
        begin
            if (index_queue.size() != 0 && !sender_hold
                && (steady || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                ramp_index <= index_queue.pop_front();
                ramp_valid <= 1'b1;
            end
            else
                ramp_valid <= 1'b0;
        end
        level_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // monitor, checker and watchdog
    always @(posedge clk)
    begin
        in_fire  = rst_n && ramp_valid && ramp_ready;
        out_fire = rst_n && level_valid && level_ready;
        if (in_fire)
            level_queue.push_back(predict_levels(ramp_index, kelvin_cfg, gain_cfg));
        if (out_fire)
        begin
            got.level[RED]   = red_level;
            got.level[GREEN] = green_level;
            got.level[BLUE]  = blue_level;
            if (level_queue.size() == 0)
                report($sformatf("unexpected beat r=%0d g=%0d b=%0d",
                                 red_level, green_level, blue_level));
            else
            begin
                want = level_queue.pop_front();
                for (int i = 0; i < 3; i++)
                    if (got.level[i] !== want.level[i])
                        report($sformatf("%s index %0d (K=%0d gain=%0d): got %0d, expected %0d",
                                         channel_e'(i) == RED ? "red" :
                                         channel_e'(i) == GREEN ? "green" : "blue",
                                         want.index, kelvin_cfg, gain_cfg,
                                         got.level[i], want.level[i]));
            end
        end
        if (!rst_n || in_fire || out_fire)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // wait until no beat is in flight; optionally also for the pending indexes
    task automatic wait_quiet(input bit with_pending);
        do
        begin
            @(posedge clk);
            #1;
        end
        while (ramp_valid || level_queue.size() != 0
               || (with_pending && index_queue.size() != 0));
    endtask

    task automatic write_reg(input logic [ctgr_pkg::ADDR_W-1:0] addr,
                             input logic [ctgr_pkg::DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ctgr_pkg::REG_KELVIN)
            kelvin_cfg = data[ctgr_pkg::KELVIN_W-1:0];
        else
            gain_cfg = data[ctgr_pkg::GAIN_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drain, then program both registers
    task automatic set_config(input logic [ctgr_pkg::DATA_W-1:0] kel,
                              input logic [ctgr_pkg::DATA_W-1:0] gn);
        wait_quiet(1'b1);
        write_reg(ctgr_pkg::REG_KELVIN, kel);
        write_reg(ctgr_pkg::REG_GAIN, gn);
    endtask

    int unsigned kelvin_pick [8] = '{0, 999, 1000, 1001, 9999, 10000, 10001, 16383};
    int unsigned gain_pick   [8] = '{0, 409, 410, 411, 4095, 4096, 4097, 8191};

    initial
    begin
        int unsigned n;
        int unsigned style;
        logic [ctgr_pkg::DATA_W-1:0] kel;
        logic [ctgr_pkg::DATA_W-1:0] gn;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings, index extremes and alternating bits
        index_queue = '{8'd0, 8'd255, 8'd1, 8'd128, 8'h55, 8'hAA};
        // temperature and brightness below their floors
        set_config(0, 0);
        index_queue = '{8'd255, 8'd128};
        set_config(999, 409);
        index_queue = '{8'd255};
        // both registers at full scale, above their ceilings
        set_config(16383, 8191);
        index_queue = '{8'd255, 8'd200};
        // top of the table
        set_config(10000, 4096);
        index_queue = '{8'd255, 8'd1};
        set_config(9999, 4097);
        index_queue = '{8'd255};
        set_config(10001, 410);
        index_queue = '{8'd255};
        set_config(1000, 410);
        index_queue = '{8'd255, 8'd0};
        set_config(1099, 4096);
        index_queue = '{8'd255};
        set_config(1050, 2048);
        index_queue = '{8'd77, 8'd255};

        for (int phase = 0; phase < 28; phase++)
        begin
            style = $urandom_range(0, 5);
            if (style == 1)
            begin
                // upper bits of the write data must be dropped
                kel = $urandom;
                gn  = $urandom;
            end
            else if (style == 2)
            begin
                kel = kelvin_pick[$urandom_range(0, 7)];
                gn  = gain_pick[$urandom_range(0, 7)];
            end
            else
            begin
                kel = $urandom_range(K_MIN, K_MAX);
                gn  = $urandom_range(G_MIN, G_ONE);
            end
            set_config(kel, gn);
            steady = (phase == 10);
            n = steady ? 80 : $urandom_range(20, 40);
            for (int i = 0; i < n; i++)
                index_queue.push_back(random_index());
            if (phase == 5 || phase == 17)
            begin
                while (index_queue.size() > n / 2)
                    @(posedge clk);
                sender_hold = 1'b1;
                wait_quiet(1'b0);
                sender_hold = 1'b0;
            end
        end

        wait_quiet(1'b1);
        steady = 1'b0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
